// ===== hw/rtl/pde_pkg.sv =====
// ----------------------------------------------------------------------------
// pde_pkg
// Shared types and constants for the polynomial derivative evaluator.
// ----------------------------------------------------------------------------
package pde_pkg;

	// fixed field widths
	localparam int DATA_W  = 32;
	localparam int DEG_W   = 3;
	localparam int ORDER_W = 3;
	localparam int CIDX_W  = 3;
	localparam int FF_W    = 10;

	// highest coefficient index the table covers
	localparam int TAB_DEG = 6;

	// configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		CFG_DEGREE = 3'd0,
		CFG_COEF_0 = 3'd1
	} cfg_idx_t;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [FF_W-1:0]   ff_t;

	// falling factorial i!/(i-k)!, zero where k exceeds i
	localparam ff_t FF_TAB [0:TAB_DEG][0:(1<<ORDER_W)-1] = '{
		'{10'd1, 10'd0, 10'd0,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
		'{10'd1, 10'd1, 10'd0,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
		'{10'd1, 10'd2, 10'd2,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
		'{10'd1, 10'd3, 10'd6,  10'd6,   10'd0,   10'd0,   10'd0,   10'd0},
		'{10'd1, 10'd4, 10'd12, 10'd24,  10'd24,  10'd0,   10'd0,   10'd0},
		'{10'd1, 10'd5, 10'd20, 10'd60,  10'd120, 10'd120, 10'd0,   10'd0},
		'{10'd1, 10'd6, 10'd30, 10'd120, 10'd360, 10'd720, 10'd720, 10'd0}
	};

endpackage

// ===== hw/rtl/polynomial_derivative_eval.sv =====
// ----------------------------------------------------------------------------
// polynomial_derivative_eval
// Pipelined Horner evaluation of the k-th derivative of an integer polynomial.
// ----------------------------------------------------------------------------
// The block takes one item (node, deriv_order) in every clock cycle while busy
// is low, and returns its value marked by a one-cycle done strobe; there is no
// back-pressure on the result side. The pipeline has one stage that scales the
// coefficients by the falling factorial, one stage that aligns them to the
// derivative order, and then one multiply-add stage per coefficient that runs
// the Horner recurrence. busy is high only from reset until the ready flag is
// set after reset is released.
// Coefficients and degree must be written while no item is in flight.
// All arithmetic wraps modulo 2^32.
module polynomial_derivative_eval
	import pde_pkg::*;
#(
	parameter int MAX_DEGREE = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// item input
	input  logic                      start,
	output logic                      busy,
	input  logic signed [DATA_W-1:0]  node,
	input  logic        [ORDER_W-1:0] deriv_order,
	// result output
	output logic                      done,
	output logic signed [DATA_W-1:0]  value,
	// configuration write port
	input  logic                      cfg_we,
	input  logic        [CIDX_W-1:0]  cfg_index,
	input  logic        [DATA_W-1:0]  cfg_wdata
);

	localparam int NCOEF = MAX_DEGREE + 1;
	localparam int LAT   = MAX_DEGREE + 3;

	// configuration registers
	logic [DEG_W-1:0] degree_q;
	word_t            coef_q [0:MAX_DEGREE];
	logic             ready_q;

	// stage 1: scaled coefficients
	logic             valid_s1;
	word_t            x_s1;
	logic [ORDER_W-1:0] k_s1;
	word_t            scaled_s1 [0:MAX_DEGREE];
	word_t            scaled_next [0:MAX_DEGREE];

	// stage 2: coefficients aligned to the derivative order
	logic             valid_s2;
	word_t            x_s2;
	word_t            align_s2 [0:MAX_DEGREE];
	word_t            align_next [0:MAX_DEGREE];
	logic [DEG_W-1:0] deg_eff;

	// horner stages, one per coefficient
	logic             valid_sh [0:MAX_DEGREE];
	word_t            x_sh     [0:MAX_DEGREE];
	word_t            acc_sh   [0:MAX_DEGREE];
	word_t            ecoef_sh [0:MAX_DEGREE][0:MAX_DEGREE];
	word_t            acc_next [0:MAX_DEGREE];

	logic             accept;

	assign busy   = ~ready_q;
	assign accept = start & ready_q;

	// ready flag, cleared by reset and set on the clock after its release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			for (int i = 0; i < NCOEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_DEGREE) begin
				degree_q <= cfg_wdata[DEG_W-1:0];
			end
			for (int i = 0; i < NCOEF; i++) begin
				if (cfg_index == CIDX_W'(int'(CFG_COEF_0) + i)) begin
					coef_q[i] <= cfg_wdata;
				end
			end
		end
	end

	// degree saturated to the supported maximum
	assign deg_eff = (degree_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_q;

	// scale each coefficient by i!/(i-k)!
	always_comb begin
		for (int i = 0; i < NCOEF; i++) begin
			scaled_next[i] = coef_q[i] * DATA_W'(FF_TAB[i][deriv_order]);
		end
	end

	// shift coefficients down by k, drop those above the degree
	always_comb begin
		for (int j = 0; j < NCOEF; j++) begin
			align_next[j] = '0;
			for (int m = 0; m < NCOEF; m++) begin
				if (({1'b0, k_s1} + (ORDER_W+1)'(j) == (ORDER_W+1)'(m)) &&
				    (DEG_W'(m) <= deg_eff)) begin
					align_next[j] = scaled_s1[m];
				end
			end
		end
	end

	// horner multiply-add, top coefficient first
	always_comb begin
		acc_next[0] = align_s2[MAX_DEGREE];
		for (int h = 1; h < NCOEF; h++) begin
			acc_next[h] = acc_sh[h-1] * x_sh[h-1] + ecoef_sh[h-1][MAX_DEGREE-h];
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int h = 0; h < NCOEF; h++) begin
				valid_sh[h] <= 1'b0;
			end
		end else begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			valid_sh[0] <= valid_s2;
			for (int h = 1; h < NCOEF; h++) begin
				valid_sh[h] <= valid_sh[h-1];
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		x_s1 <= node;
		k_s1 <= deriv_order;
		for (int i = 0; i < NCOEF; i++) begin
			scaled_s1[i] <= scaled_next[i];
		end
		x_s2 <= x_s1;
		for (int j = 0; j < NCOEF; j++) begin
			align_s2[j] <= align_next[j];
		end
		x_sh[0]   <= x_s2;
		acc_sh[0] <= acc_next[0];
		for (int j = 0; j < NCOEF; j++) begin
			ecoef_sh[0][j] <= align_s2[j];
		end
		for (int h = 1; h < NCOEF; h++) begin
			x_sh[h]   <= x_sh[h-1];
			acc_sh[h] <= acc_next[h];
			for (int j = 0; j < NCOEF; j++) begin
				ecoef_sh[h][j] <= ecoef_sh[h-1][j];
			end
		end
	end

	// result
	assign done  = valid_sh[MAX_DEGREE];
	assign value = signed'(acc_sh[MAX_DEGREE]);

	// the done strobe marks each accepted item once it leaves the pipeline
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, LAT))
		else $error("result strobe does not match accepted item");

	// an order above any degree gives zero
	a_order_seven_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(deriv_order, LAT) == 3'd7) |-> value == '0)
		else $error("order seven gave a nonzero value");

	// once ready, the block stays ready
	a_ready_stays: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polynomial derivative evaluator.
// ----------------------------------------------------------------------------
// Loads the degree and coefficient registers, then streams (node, order) items,
// some phases with random gaps. A scoreboard runs its own Horner evaluation of
// the k-th derivative for each accepted item. It compares every done strobe
// against the oldest pending value. Registers are rewritten only once the
// pipeline has drained.
module tb;
	import pde_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DEG    = 6;
	localparam int NUM_COEF   = MAX_DEG + 1;
	localparam int LATENCY    = MAX_DEG + 3;
	localparam int STALL_LIM  = 2000;
	localparam int RAND_PHASE = 10;
	localparam int PHASE_ITEMS = 140;

	// expected derivative values, in item order
	class deriv_scoreboard;
		logic [DEG_W-1:0] degree;
		word_t            coefs [NUM_COEF];
		word_t            expected_values [$];
		int               errors;

		function new();
			degree = '0;
			foreach (coefs[i]) coefs[i] = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CIDX_W-1:0] idx, word_t data);
			if (idx == CFG_DEGREE) begin
				degree = data[DEG_W-1:0];
			end else if (int'(idx) - int'(CFG_COEF_0) < NUM_COEF) begin
				coefs[int'(idx) - int'(CFG_COEF_0)] = data;
			end
		endfunction

		// horner over coef_i * i!/(i-k)! from the top coefficient down to k
		function word_t horner_deriv(word_t x, int k);
			int    top;
			word_t acc;
			word_t ff;
			top = (degree > MAX_DEG) ? MAX_DEG : int'(degree);
			acc = '0;
			if (k <= top) begin
				for (int i = top; i >= k; i--) begin
					ff = 32'd1;
					for (int j = 0; j < k; j++) ff = ff * word_t'(i - j);
					acc = acc * x + ff * coefs[i];
				end
			end
			return acc;
		endfunction

		function void note_item(word_t x, logic [ORDER_W-1:0] k);
			expected_values.push_back(horner_deriv(x, int'(k)));
		endfunction

		function void check_value(word_t actual);
			word_t want;
			if (expected_values.size() == 0) begin
				$error("value: no item pending, actual %0d", $signed(actual));
				errors++;
			end else begin
				want = expected_values.pop_front();
				if (want !== actual) begin
					$error("value: expected %0d, actual %0d", $signed(want), $signed(actual));
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_values.size();
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [DATA_W-1:0]  node;
	logic        [ORDER_W-1:0] deriv_order;
	logic                      done;
	logic signed [DATA_W-1:0]  value;
	logic                      cfg_we;
	logic        [CIDX_W-1:0]  cfg_index;
	logic        [DATA_W-1:0]  cfg_wdata;

	deriv_scoreboard sb;
	int              stall_cycles;
	bit              gapless;

	polynomial_derivative_eval #(
		.MAX_DEGREE(MAX_DEG)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.node(node),
		.deriv_order(deriv_order),
		.done(done),
		.value(value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sample accepted items, register writes and results
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_value(value);
			if (cfg_we) sb.set_reg(cfg_index, cfg_wdata);
			if (start && !busy) sb.note_item(node, deriv_order);
		end
	end

	// watchdog on cycles with no handshake of any kind
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIM) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// mix of small signed values, corner values and full-range words
	function automatic word_t rand_word();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return word_t'(int'($urandom_range(0, 32)) - 16);
			4: begin
				case ($urandom_range(0, 4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					3: return 32'h0000_0001;
					default: return 32'h0000_0000;
				endcase
			end
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic write_reg(logic [CIDX_W-1:0] idx, word_t data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// degree register gets random upper bits, only the low bits count
	task automatic load_poly(logic [DEG_W-1:0] deg, word_t c [NUM_COEF]);
		write_reg(CFG_DEGREE, {$urandom} & ~word_t'({DEG_W{1'b1}}) | word_t'(deg));
		for (int i = 0; i < NUM_COEF; i++) begin
			write_reg(CIDX_W'(int'(CFG_COEF_0) + i), c[i]);
		end
	endtask

	task automatic send_item(word_t x, logic [ORDER_W-1:0] k);
		@(negedge clk);
		start       = 1'b1;
		node        = x;
		deriv_order = k;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// idle gap: mostly short, a few long
	task automatic idle_gap();
		int len;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: len = 0;
			6, 7, 8:          len = $urandom_range(1, 3);
			default:          len = $urandom_range(5, 30);
		endcase
		repeat (len) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// let the pipeline empty before touching registers
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	initial begin
		word_t            c [NUM_COEF];
		logic [DEG_W-1:0] deg;
		int               top;

		start        = 1'b0;
		node         = '0;
		deriv_order  = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		stall_cycles = 0;
		arst_n       = 1'b0;
		sb           = new();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// registers at their reset values
		send_item(32'h7FFF_FFFF, 3'd0);
		send_item(32'h8000_0000, 3'd7);
		drain();

		// full degree, small mixed-sign coefficients, orders 0 to 4, 6 and 7
		c = '{32'd3, -32'sd2, 32'd5, -32'sd7, 32'd11, -32'sd13, 32'd17};
		load_poly(3'd6, c);
		send_item(32'd0, 3'd0);
		send_item(32'd1, 3'd0);
		send_item(-32'sd1, 3'd1);
		send_item(32'd2, 3'd3);
		send_item(-32'sd3, 3'd6);
		send_item(32'd5, 3'd7);
		send_item(32'h7FFF_FFFF, 3'd0);
		send_item(32'h8000_0000, 3'd2);
		send_item(32'h7FFF_FFFF, 3'd6);
		send_item(32'd9, 3'd4);
		drain();

		// degree 7 saturates to 6, extreme coefficients wrap
		c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
		load_poly(3'd7, c);
		send_item(32'd2, 3'd0);
		send_item(-32'sd1, 3'd5);
		send_item(32'd1, 3'd6);
		send_item(32'd3, 3'd7);
		drain();

		// degree 0: upper coefficients hold junk and must be ignored
		foreach (c[i]) c[i] = word_t'($urandom);
		load_poly(3'd0, c);
		send_item(word_t'($urandom), 3'd0);
		send_item(word_t'($urandom), 3'd1);
		send_item(32'h8000_0000, 3'd0);
		drain();

		// random phases, each with a fresh polynomial
		for (int p = 0; p < RAND_PHASE; p++) begin
			deg = DEG_W'($urandom_range(0, 7));
			foreach (c[i]) c[i] = rand_word();
			load_poly(deg, c);
			top     = (deg > MAX_DEG) ? MAX_DEG : int'(deg);
			gapless = ($urandom_range(0, 2) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) < 7) begin
					send_item(rand_word(), 3'($urandom_range(0, top)));
				end else begin
					send_item(rand_word(), 3'($urandom_range(0, 7)));
				end
				if (!gapless) idle_gap();
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/pde_pkg.sv
hw/rtl/polynomial_derivative_eval.sv
tb/tb.sv
